>>> sv/u2u_pkg.sv
package u2u_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INCOMPLETE = 3'd1,
    ST_ILLEGAL    = 3'd2,
    ST_PENDING    = 3'd3,
    ST_RESET      = 3'd4
  } status_t;

  typedef enum logic {
    OP_CONVERT = 1'b0,
    OP_RESET   = 1'b1
  } op_t;

  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [7:0] byte_fourth;
    logic [2:0] bytes_available;
  } in_item_t;

  typedef struct packed {
    logic [15:0] unit;
    status_t     status;
    logic [2:0]  consumed;
  } out_item_t;

  // decoder result plus the store contents to keep once the item leaves the input register
  typedef struct packed {
    out_item_t   res;
    logic [15:0] pend_nxt;
  } dec_res_t;

endpackage

>>> sv/u2u_if.sv
interface u2u_in_if;
  import u2u_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface u2u_out_if;
  import u2u_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

>>> sv/utf8_to_utf16_converter.sv
// channel  dir  payload                                           handshake
// in_ch    in   operation, byte_first..byte_fourth, bytes_avail  valid/ready
// out_ch   out  unit, status, consumed                            valid/ready
//
// one item per cycle sustained while out_ch is not stalled; an accepted item passes
// through the input register, the decode and the result register
// the stored low surrogate is read and updated in the decode step, so the
// next item sees it without a gap
// rst_n (synchronous) empties both registers and clears the stored surrogate
// a stalled result holds; the input register refills whenever the result moves on
module utf8_to_utf16_converter (
  input  logic       clk,
  input  logic       rst_n,
  u2u_in_if.sink     in_ch,
  u2u_out_if.source  out_ch
);
  import u2u_pkg::*;

  logic      stage_v_r;
  in_item_t  stage_r;
  logic      out_v_r;
  out_item_t out_r;
  logic [15:0] pending_low_r;
  dec_res_t  dec;
  logic      advance;

  u2u_decode u_decode (
    .item     (stage_r),
    .pend_low (pending_low_r),
    .dec      (dec)
  );

  assign advance     = stage_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !stage_v_r || advance;
  assign out_ch.valid = out_v_r;
  assign out_ch.item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r     <= 1'b0;
      out_v_r       <= 1'b0;
      pending_low_r <= '0;
    end else begin
      if (in_ch.ready) stage_v_r <= in_ch.valid;
      if (advance) begin
        out_v_r       <= 1'b1;
        pending_low_r <= dec.pend_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) stage_r <= in_ch.item;
    if (advance) out_r <= dec.res;
  end

  // error and reset results carry no unit and no byte count
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_r.status == ST_ILLEGAL || out_r.status == ST_INCOMPLETE ||
                out_r.status == ST_RESET)
    |-> out_r.unit == '0 && out_r.consumed == '0)
    else $error("error result with nonzero unit or count");

  // a stored unit is always a low surrogate
  a_pend_low: assert property (@(posedge clk) disable iff (!rst_n)
    pending_low_r != '0 |-> pending_low_r[15:10] == LO_SURR_TAG)
    else $error("stored unit is not a low surrogate");

  // a high surrogate sent out leaves a low one stored
  a_hi_stores: assert property (@(posedge clk) disable iff (!rst_n)
    advance && dec.res.status == ST_OK && dec.res.unit[15:10] == HI_SURR_TAG
    |=> pending_low_r != '0)
    else $error("high surrogate given without storing the low one");

  // a waiting item is not lost while the result is stalled
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stage_v_r && !advance |=> stage_v_r && $stable(stage_r))
    else $error("waiting item dropped");

  // the stored surrogate only leaves as a pending result
  a_pend_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stage_r.operation == OP_CONVERT && pending_low_r != '0
    |=> out_r.status == ST_PENDING && pending_low_r == '0)
    else $error("stored unit not delivered");

endmodule

>>> sv/u2u_decode.sv
module u2u_decode (
  input  u2u_pkg::in_item_t  item,
  input  logic [15:0]        pend_low,
  output u2u_pkg::dec_res_t  dec
);
  import u2u_pkg::*;

  logic [7:0]  b0, b1, b2, b3;
  logic [2:0]  avail;
  logic [2:0]  len;
  logic        bad_lead;
  logic        cont1_ok, cont2_ok, cont3_ok;
  logic [10:0] cp2;
  logic [15:0] cp3;
  logic [20:0] cp4;
  logic [19:0] supp;

  always_comb begin
    b0 = item.byte_first;
    b1 = item.byte_second;
    b2 = item.byte_third;
    b3 = item.byte_fourth;
    avail = item.bytes_available[2] ? 3'd4 : item.bytes_available;

    bad_lead = 1'b0;
    len = 3'd1;
    if (b0[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b0[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b0[7:3] == 5'b11110) begin
      len = 3'd4;
    end else if (b0[7]) begin
      bad_lead = 1'b1;
    end

    cont1_ok = (b1[7:6] == 2'b10);
    cont2_ok = (b2[7:6] == 2'b10);
    cont3_ok = (b3[7:6] == 2'b10);

    cp2  = {b0[4:0], b1[5:0]};
    cp3  = {b0[3:0], b1[5:0], b2[5:0]};
    cp4  = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    supp = 20'(cp4 - SUPP_BASE);
  end

  always_comb begin
    dec.res.unit     = '0;
    dec.res.status   = ST_ILLEGAL;
    dec.res.consumed = '0;
    dec.pend_nxt     = pend_low;

    if (item.operation == OP_RESET) begin
      // a stored low surrogate blocks the reset and stays
      if (pend_low == '0) dec.res.status = ST_RESET;
    end else if (pend_low != '0) begin
      dec.res.unit   = pend_low;
      dec.res.status = ST_PENDING;
      dec.pend_nxt   = '0;
    end else if (avail == 3'd0) begin
      dec.res.status = ST_INCOMPLETE;
    end else if (bad_lead) begin
      dec.res.status = ST_ILLEGAL;
    end else if (avail < len) begin
      dec.res.status = ST_INCOMPLETE;
    end else begin
      case (len)
        3'd1: begin
          dec.res.unit     = {8'h00, b0};
          dec.res.status   = ST_OK;
          dec.res.consumed = 3'd1;
        end
        3'd2: begin
          if (cont1_ok && cp2 >= 11'h080) begin
            dec.res.unit     = {5'd0, cp2};
            dec.res.status   = ST_OK;
            dec.res.consumed = 3'd2;
          end
        end
        3'd3: begin
          // overlong forms and surrogate code points are rejected
          if (cont1_ok && cont2_ok && cp3 >= 16'h0800 && cp3[15:11] != 5'b11011) begin
            dec.res.unit     = cp3;
            dec.res.status   = ST_OK;
            dec.res.consumed = 3'd3;
          end
        end
        3'd4: begin
          if (cont1_ok && cont2_ok && cont3_ok && cp4 >= SUPP_BASE && cp4 <= CP_MAX) begin
            dec.res.unit     = HI_SURR_BASE + {6'd0, supp[19:10]};
            dec.res.status   = ST_OK;
            dec.res.consumed = 3'd4;
            dec.pend_nxt     = {LO_SURR_TAG, supp[9:0]};
          end
        end
        default: begin
          dec.res.status = ST_ILLEGAL;
        end
      endcase
    end
  end

endmodule
